>>> rtl/dqbct_pkg.sv
// Shared types, constants and the bit-count function of the deque with bit-count tally.
package dqbct_pkg;

   localparam int WORD_BITS      = 32;
   localparam int TALLY_BITS     = 48;
   localparam int TAKEN_BITS     = 32;
   localparam int COUNT_BITS     = 6;
   localparam int OCC_BITS       = 11;
   localparam int OP_BITS        = 2;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 8;
   localparam int DEPTH_DEFAULT  = 1024;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH       = 2'd0,
      OP_TAKE_FRONT = 2'd1,
      OP_TAKE_BACK  = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRONT_ONES = 8'd0,
      CSR_BACK_ONES  = 8'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECIDE,
      FSM_READ,
      FSM_ADD,
      FSM_RESPOND
   } state_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   operation;
      logic [WORD_BITS-1:0] push_word;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   taken_word;
      logic [COUNT_BITS-1:0]  bits_counted;
      logic [TALLY_BITS-1:0]  end_tally;
      logic [TAKEN_BITS-1:0]  end_taken_count;
      logic [OCC_BITS-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic front_counts_ones;
      logic back_counts_ones;
   } cfg_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   function automatic logic [COUNT_BITS-1:0] popcount(input logic [WORD_BITS-1:0] w);
      logic [WORD_BITS-1:0] x;
      x = w - ((w >> 1) & 32'h5555_5555);
      x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
      x = (x + (x >> 4)) & 32'h0F0F_0F0F;
      return COUNT_BITS'(x[7:0]) + COUNT_BITS'(x[15:8])
           + COUNT_BITS'(x[23:16]) + COUNT_BITS'(x[31:24]);
   endfunction

endpackage

>>> rtl/dqbct_mem.sv
// Word store: one write port and one read port with registered read data.
module dqbct_mem #(
   parameter int DEPTH = dqbct_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  dqbct_pkg::mem_ctl_type              ctl,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [dqbct_pkg::WORD_BITS-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [dqbct_pkg::WORD_BITS-1:0]     rd_data
);
   import dqbct_pkg::*;

   logic [WORD_BITS-1:0] store_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dqbct_ctrl.sv
// Sequencer: ring pointers, fill count, per-end tallies and result register.
module dqbct_ctrl #(
   parameter int DEPTH = dqbct_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  dqbct_pkg::req_type                  req,
   input  dqbct_pkg::cfg_type                  cfg,
   output logic                                rsp_valid,
   output dqbct_pkg::rsp_type                  rsp,
   output dqbct_pkg::mem_ctl_type              mem_ctl,
   output logic [$clog2(DEPTH)-1:0]            wr_addr,
   output logic [dqbct_pkg::WORD_BITS-1:0]     wr_data,
   output logic [$clog2(DEPTH)-1:0]            rd_addr,
   input  logic [dqbct_pkg::WORD_BITS-1:0]     rd_data
);
   import dqbct_pkg::*;

   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int FILL_BITS = $clog2(DEPTH + 1);
   localparam logic [ADDR_BITS-1:0] LAST_IDX  = ADDR_BITS'(DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(DEPTH);

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [ADDR_BITS-1:0]    front_ff, front_in;
   logic [ADDR_BITS-1:0]    back_ff, back_in;
   logic [FILL_BITS-1:0]    fill_ff, fill_in;
   logic [TALLY_BITS-1:0]   front_tally_ff, front_tally_in;
   logic [TALLY_BITS-1:0]   back_tally_ff, back_tally_in;
   logic [TAKEN_BITS-1:0]   front_taken_ff, front_taken_in;
   logic [TAKEN_BITS-1:0]   back_taken_ff, back_taken_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    at_front_ff, at_front_in;
   logic [ADDR_BITS-1:0]    back_prev;
   logic [COUNT_BITS-1:0]   ones;
   logic                    count_ones;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_IDLE;
         front_ff       <= '0;
         back_ff        <= '0;
         fill_ff        <= '0;
         front_tally_ff <= '0;
         back_tally_ff  <= '0;
         front_taken_ff <= '0;
         back_taken_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         front_ff       <= front_in;
         back_ff        <= back_in;
         fill_ff        <= fill_in;
         front_tally_ff <= front_tally_in;
         back_tally_ff  <= back_tally_in;
         front_taken_ff <= front_taken_in;
         back_taken_ff  <= back_taken_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      count_ff    <= count_in;
      at_front_ff <= at_front_in;
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      fill_in        = fill_ff;
      front_tally_in = front_tally_ff;
      back_tally_in  = back_tally_ff;
      front_taken_in = front_taken_ff;
      back_taken_in  = back_taken_ff;
      count_in       = count_ff;
      at_front_in    = at_front_ff;
      mem_ctl        = '0;
      wr_addr        = back_ff;
      wr_data        = req_ff.push_word;
      back_prev      = (back_ff == '0) ? LAST_IDX : back_ff - ADDR_BITS'(1);
      rd_addr        = front_ff;
      ones           = popcount(rd_data);
      count_ones     = at_front_ff ? cfg.front_counts_ones : cfg.back_counts_ones;
      busy           = (state_ff != FSM_IDLE);
      rsp_valid      = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: begin
            rsp_in           = '0;
            rsp_in.status    = STATUS_DONE;
            rsp_in.occupancy = OCC_BITS'(fill_ff);
            state_in         = FSM_RESPOND;
            case (req_ff.operation)
               OP_PUSH: begin
                  if (fill_ff == FULL_FILL) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     mem_ctl.wr_en    = 1'b1;
                     back_in          = (back_ff == LAST_IDX) ? '0 : back_ff + ADDR_BITS'(1);
                     fill_in          = fill_ff + FILL_BITS'(1);
                     rsp_in.occupancy = OCC_BITS'(fill_in);
                  end
               end
               OP_TAKE_FRONT: begin
                  at_front_in = 1'b1;
                  if (fill_ff == '0) begin
                     rsp_in.status          = STATUS_EMPTY;
                     rsp_in.end_tally       = front_tally_ff;
                     rsp_in.end_taken_count = front_taken_ff;
                  end else begin
                     mem_ctl.rd_en    = 1'b1;
                     rd_addr          = front_ff;
                     front_in         = (front_ff == LAST_IDX) ? '0 : front_ff + ADDR_BITS'(1);
                     fill_in          = fill_ff - FILL_BITS'(1);
                     rsp_in.occupancy = OCC_BITS'(fill_in);
                     state_in         = FSM_READ;
                  end
               end
               OP_TAKE_BACK: begin
                  at_front_in = 1'b0;
                  if (fill_ff == '0) begin
                     rsp_in.status          = STATUS_EMPTY;
                     rsp_in.end_tally       = back_tally_ff;
                     rsp_in.end_taken_count = back_taken_ff;
                  end else begin
                     mem_ctl.rd_en    = 1'b1;
                     rd_addr          = back_prev;
                     back_in          = back_prev;
                     fill_in          = fill_ff - FILL_BITS'(1);
                     rsp_in.occupancy = OCC_BITS'(fill_in);
                     state_in         = FSM_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         FSM_READ: begin
            rsp_in.taken_word = rd_data;
            count_in = count_ones ? ones : COUNT_BITS'(WORD_BITS) - ones;
            state_in = FSM_ADD;
         end
         FSM_ADD: begin
            rsp_in.bits_counted = count_ff;
            if (at_front_ff) begin
               front_tally_in         = front_tally_ff + TALLY_BITS'(count_ff);
               front_taken_in         = front_taken_ff + TAKEN_BITS'(1);
               rsp_in.end_tally       = front_tally_in;
               rsp_in.end_taken_count = front_taken_in;
            end else begin
               back_tally_in          = back_tally_ff + TALLY_BITS'(count_ff);
               back_taken_in          = back_taken_ff + TAKEN_BITS'(1);
               rsp_in.end_tally       = back_tally_in;
               rsp_in.end_taken_count = back_taken_in;
            end
            state_in = FSM_RESPOND;
         end
         FSM_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp = rsp_ff;

endmodule

>>> rtl/deque_with_bit_count_tally.sv
// Top level: bounded deque of words with per-end bit-count tallies.
// One operation at a time. An operation is taken when start is high and busy is low;
// its single result appears on rsp_payload for one cycle with rsp_valid high and must be
// taken then. A push, a take from an empty queue or an unused code steps through accept,
// decide and respond; a successful take steps through accept, decide and issue read, bit
// count on the read word, tally add and respond. The word memory needs no clearing
// after reset. Configuration writes are taken whenever busy and start are both low.
module deque_with_bit_count_tally #(
   parameter int DEPTH = dqbct_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  dqbct_pkg::req_type                   req_payload,
   output logic                                 rsp_valid,
   output dqbct_pkg::rsp_type                   rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dqbct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic                                 csr_data
);
   import dqbct_pkg::*;

   localparam int ADDR_BITS = $clog2(DEPTH);

   cfg_type                cfg_ff, cfg_in;
   mem_ctl_type            mem_ctl;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic [WORD_BITS-1:0]   rd_data;

   assign csr_ready = ~busy & ~start;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRONT_ONES: cfg_in.front_counts_ones = csr_data;
            CSR_BACK_ONES:  cfg_in.back_counts_ones  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_counts_ones <= 1'b0;
         cfg_ff.back_counts_ones  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dqbct_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_payload),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   dqbct_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_FULL |-> rsp_payload.occupancy == OCC_BITS'(DEPTH))
      else $error("full reported below capacity");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_EMPTY
      |-> rsp_payload.occupancy == '0 && rsp_payload.taken_word == '0)
      else $error("empty reported with words present");

endmodule

>>> sim/tb_deque_with_bit_count_tally.sv
// Self-checking testbench for the bounded word deque with per-end bit-count tallies.
module tb_deque_with_bit_count_tally;
   timeunit 1ns;
   timeprecision 1ps;

   import dqbct_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [OP_BITS-1:0]        OP_SPARE     = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 8'd9;

   typedef enum logic [1:0] {
      STEP_ITEM,
      STEP_CSR,
      STEP_IDLE,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type             kind;
      req_type                   req;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic                      csr_val;
      int unsigned               cycles;
   } plan_step_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic    csr_data = 1'b0;

   // predicted deque state
   logic [WORD_BITS-1:0]  ring_words [DEPTH];
   int unsigned           ring_head = 0;
   int unsigned           ring_tail = 0;
   int unsigned           ring_fill = 0;
   logic [TALLY_BITS-1:0] front_tally = '0;
   logic [TALLY_BITS-1:0] back_tally = '0;
   logic [TAKEN_BITS-1:0] front_taken = '0;
   logic [TAKEN_BITS-1:0] back_taken = '0;
   cfg_type               tally_cfg = '{front_counts_ones: 1'b0, back_counts_ones: 1'b1};

   // planning shadow of the deque pointers
   int unsigned plan_tail = 0;
   int unsigned plan_fill = 0;
   bit          tail_wrapped = 1'b0;
   bit          idle_bursts = 1'b1;
   bit          quiet_tail = 1'b0;

   plan_step_type op_plan [$];
   rsp_type       predicted_rsp [$];
   int unsigned   idle_left = 0;
   bit            draining = 1'b0;
   int unsigned   ops_predicted = 0;
   int unsigned   rsps_seen = 0;
   int unsigned   fail_count = 0;

   deque_with_bit_count_tally #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("** deque_with_bit_count_tally: FAILED **");
      $finish;
   end

   function automatic rsp_type predict_op(req_type r);
      rsp_type              o;
      logic [WORD_BITS-1:0] w;
      int unsigned          n;
      o = '0;
      case (r.operation)
         OP_PUSH: begin
            if (ring_fill == DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               ring_words[ring_tail] = r.push_word;
               ring_tail = (ring_tail + 1) % DEPTH;
               ring_fill++;
            end
         end
         OP_TAKE_FRONT: begin
            if (ring_fill == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               w = ring_words[ring_head];
               ring_head = (ring_head + 1) % DEPTH;
               ring_fill--;
               n = tally_cfg.front_counts_ones ? $countones(w) : WORD_BITS - $countones(w);
               front_tally = front_tally + TALLY_BITS'(n);
               front_taken = front_taken + TAKEN_BITS'(1);
               o.taken_word = w;
               o.bits_counted = COUNT_BITS'(n);
            end
            o.end_tally = front_tally;
            o.end_taken_count = front_taken;
         end
         OP_TAKE_BACK: begin
            if (ring_fill == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               ring_tail = (ring_tail + DEPTH - 1) % DEPTH;
               w = ring_words[ring_tail];
               ring_fill--;
               n = tally_cfg.back_counts_ones ? $countones(w) : WORD_BITS - $countones(w);
               back_tally = back_tally + TALLY_BITS'(n);
               back_taken = back_taken + TAKEN_BITS'(1);
               o.taken_word = w;
               o.bits_counted = COUNT_BITS'(n);
            end
            o.end_tally = back_tally;
            o.end_taken_count = back_taken;
         end
         default: ;
      endcase
      o.occupancy = OCC_BITS'(ring_fill);
      return o;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_BITS-1:0] idx, logic val);
      case (idx)
         CSR_FRONT_ONES: tally_cfg.front_counts_ones = val;
         CSR_BACK_ONES:  tally_cfg.back_counts_ones = val;
         default: ;
      endcase
   endfunction

   function automatic plan_step_type blank_step(step_kind_type kind);
      plan_step_type s;
      s.kind = kind;
      s.req = '0;
      s.csr_idx = '0;
      s.csr_val = 1'b0;
      s.cycles = 0;
      return s;
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom();
      endcase
   endfunction

   function automatic void plan_op(logic [OP_BITS-1:0] op, logic [WORD_BITS-1:0] w);
      plan_step_type s;
      s = blank_step(STEP_ITEM);
      s.req.operation = op;
      s.req.push_word = w;
      op_plan = {op_plan, s};
      case (op)
         OP_PUSH: begin
            if (plan_fill < DEPTH) begin
               plan_tail = (plan_tail + 1) % DEPTH;
               plan_fill++;
            end
         end
         OP_TAKE_FRONT: begin
            if (plan_fill > 0) begin
               plan_fill--;
            end
         end
         OP_TAKE_BACK: begin
            if (plan_fill > 0) begin
               if (plan_tail == 0) tail_wrapped = 1'b1;
               plan_tail = (plan_tail + DEPTH - 1) % DEPTH;
               plan_fill--;
            end
         end
         default: ;
      endcase
      if ($urandom_range(0, 39) == 0) idle_bursts = !idle_bursts;
      if (!quiet_tail && idle_bursts && $urandom_range(0, 2) == 0) begin
         s = blank_step(STEP_IDLE);
         s.cycles = $urandom_range(1, 3);
         op_plan = {op_plan, s};
      end
   endfunction

   function automatic void plan_random_op(int w_push, int w_front, int w_back);
      int r;
      r = $urandom_range(0, 99);
      if (r < w_push) plan_op(OP_PUSH, random_word());
      else if (r < w_push + w_front) plan_op(OP_TAKE_FRONT, $urandom());
      else if (r < w_push + w_front + w_back) plan_op(OP_TAKE_BACK, $urandom());
      else plan_op(OP_SPARE, $urandom());
   endfunction

   function automatic void plan_csr(logic [CSR_INDEX_BITS-1:0] idx, logic val);
      plan_step_type s;
      s = blank_step(STEP_CSR);
      s.csr_idx = idx;
      s.csr_val = val;
      op_plan = {op_plan, s};
   endfunction

   function automatic void plan_drain();
      op_plan = {op_plan, blank_step(STEP_DRAIN)};
   endfunction

   function automatic void build_plan();
      // empty deque, reset tally selects
      plan_op(OP_TAKE_FRONT, $urandom());
      plan_op(OP_TAKE_BACK, $urandom());
      plan_op(OP_SPARE, $urandom());
      plan_op(OP_PUSH, 32'h0000_0000);
      plan_op(OP_PUSH, 32'hFFFF_FFFF);
      plan_op(OP_PUSH, 32'hAAAA_AAAA);
      plan_op(OP_PUSH, 32'h5555_5555);
      plan_op(OP_PUSH, 32'h8000_0001);
      plan_op(OP_SPARE, 32'hFFFF_FFFF);
      plan_op(OP_TAKE_FRONT, $urandom());
      plan_op(OP_TAKE_BACK, $urandom());
      plan_op(OP_TAKE_FRONT, $urandom());
      plan_op(OP_TAKE_BACK, $urandom());
      plan_op(OP_TAKE_BACK, $urandom());
      plan_op(OP_TAKE_BACK, $urandom());
      plan_op(OP_TAKE_FRONT, $urandom());
      plan_op(OP_PUSH, 32'hFFFF_FFFF);
      plan_op(OP_TAKE_FRONT, $urandom());
      plan_op(OP_PUSH, 32'h0000_0000);
      plan_op(OP_TAKE_BACK, $urandom());
      plan_drain();
      plan_csr(CSR_FRONT_ONES, 1'b1);
      plan_csr(CSR_BACK_ONES, 1'b0);
      plan_op(OP_PUSH, 32'hFFFF_FFFF);
      plan_op(OP_PUSH, 32'h0000_0000);
      plan_op(OP_TAKE_FRONT, $urandom());
      plan_op(OP_TAKE_BACK, $urandom());

      // shallow random traffic, pausing once until everything is back
      for (int i = 0; i < 40; i++) begin
         if (i == 20) plan_drain();
         plan_random_op(45, 28, 22);
      end
      plan_drain();
      plan_csr(CSR_UNMAPPED, 1'b1);
      plan_csr(CSR_FRONT_ONES, 1'b0);
      plan_csr(CSR_BACK_ONES, 1'b0);

      // fill to the brim, retreating the back pointer across zero once
      while (plan_fill < DEPTH) begin
         if (plan_tail == 0 && plan_fill > 0 && !tail_wrapped) plan_op(OP_TAKE_BACK, $urandom());
         else plan_random_op(93, 0, 3);
      end
      for (int i = 0; i < 3; i++) plan_op(OP_PUSH, random_word());
      plan_op(OP_SPARE, $urandom());
      for (int i = 0; i < 30; i++) plan_random_op(50, 30, 20);
      plan_drain();
      plan_csr(CSR_FRONT_ONES, 1'b1);
      plan_csr(CSR_BACK_ONES, 1'b1);

      // take words off, mostly through the front
      for (int i = 0; i < 40; i++) plan_random_op(3, 85, 10);

      quiet_tail = 1'b1;
      for (int i = 0; i < 50; i++) plan_random_op(50, 25, 20);
   endfunction

   always @(posedge clock) begin
      plan_step_type nxt_step;
      logic          next_start;
      logic          next_csr;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         next_start = start;
         next_csr = csr_valid;
         if (start && !busy) begin
            predicted_rsp = {predicted_rsp, predict_op(req_payload)};
            ops_predicted++;
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
            next_csr = 1'b0;
         end
         if (!next_start && !next_csr) begin
            if (idle_left != 0) begin
               if (!busy) idle_left--;
            end else if (draining) begin
               if (rsps_seen == ops_predicted) begin
                  draining = 1'b0;
                  idle_left = SETTLE_CYCLES;
               end
            end else if (op_plan.size() != 0) begin
               nxt_step = op_plan.pop_front();
               case (nxt_step.kind)
                  STEP_ITEM: begin
                     next_start = 1'b1;
                     req_payload <= nxt_step.req;
                  end
                  STEP_CSR: begin
                     next_csr = 1'b1;
                     csr_index <= nxt_step.csr_idx;
                     csr_data <= nxt_step.csr_val;
                  end
                  STEP_IDLE: idle_left = nxt_step.cycles;
                  STEP_DRAIN: draining = 1'b1;
                  default: ;
               endcase
            end
         end
         start <= next_start;
         csr_valid <= next_csr;
      end
   end

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsps_seen <= rsps_seen + 1;
         if (predicted_rsp.size() == 0) begin
            $error("result transaction with none outstanding: 0x%0h", rsp_payload);
            fail_count++;
         end else begin
            want = predicted_rsp.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_payload.status));
            check_field("taken_word", 64'(want.taken_word), 64'(rsp_payload.taken_word));
            check_field("bits_counted", 64'(want.bits_counted),
                        64'(rsp_payload.bits_counted));
            check_field("end_tally", 64'(want.end_tally), 64'(rsp_payload.end_tally));
            check_field("end_taken_count", 64'(want.end_taken_count),
                        64'(rsp_payload.end_taken_count));
            check_field("occupancy", 64'(want.occupancy), 64'(rsp_payload.occupancy));
         end
      end
   end

   initial begin
      build_plan();
      wait (!reset);
      do @(negedge clock);
      while (op_plan.size() != 0 || start || csr_valid || draining || idle_left != 0
             || rsps_seen != ops_predicted);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_rsp.size() != 0) begin
         $error("%0d result transactions never arrived", predicted_rsp.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("** deque_with_bit_count_tally: PASSED **");
      end else begin
         $display("** deque_with_bit_count_tally: FAILED **");
      end
      $finish;
   end

endmodule
